[rtl/core/fmtmr_pkg.sv]
// Shared types and constants for the FM chip timer/status model.
// Used by every module under rtl/core; no dependencies of its own.
package fmtmr_pkg;

  // timer tick lengths in microseconds
  localparam int unsigned T1_TICK_US = 80;
  localparam int unsigned T2_TICK_US = 320;

  localparam int unsigned NOW_W = 64;
  localparam int unsigned REG_W = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADV_W = 20;
  localparam int unsigned DELTA_W = 32;

  typedef enum logic [2:0] {
    REQ_ADDR_BANK0 = 3'd0,
    REQ_ADDR_BANK1 = 3'd1,
    REQ_DATA_WRITE = 3'd2,
    REQ_STATUS_RD  = 3'd3,
    REQ_BANK1_RD   = 3'd4,
    REQ_ADVANCE    = 3'd5
  } req_t;

  localparam logic [REG_W-1:0] REG_T1_PRELOAD = 9'h002;
  localparam logic [REG_W-1:0] REG_T2_PRELOAD = 9'h003;
  localparam logic [REG_W-1:0] REG_T_CONTROL  = 9'h004;
  localparam logic [REG_W-1:0] REG_NEW_MODE   = 9'h105;

  localparam logic [BYTE_W-1:0] STAT_IRQ      = 8'h80;
  localparam logic [BYTE_W-1:0] STAT_T1       = 8'h40;
  localparam logic [BYTE_W-1:0] STAT_T2       = 8'h20;
  localparam logic [BYTE_W-1:0] BANK1_RD_DATA = 8'hff;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [BYTE_W-1:0] value;
    logic [ADV_W-1:0]  advance_us;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              fwd_valid;
    logic [REG_W-1:0]  fwd_reg;
    logic [BYTE_W-1:0] fwd_data;
    logic              wide_mode;
  } result_t;

  // (256 - preload) * tick, at most 256 * 320
  function automatic logic [DELTA_W-1:0] timer_delta(input logic [BYTE_W-1:0] preload,
                                                     input int unsigned tick);
    logic [DELTA_W-1:0] ticks;
    ticks = DELTA_W'(9'h100 - {1'b0, preload});
    return ticks * DELTA_W'(tick);
  endfunction

endpackage

[rtl/core/fmtmr_in_reg.sv]
// Input register stage: holds one accepted beat until the core takes it.
// Depends on fmtmr_pkg.
module fmtmr_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmtmr_pkg::item_t   in_item,
  input  logic               take,
  output logic               held_valid,
  output fmtmr_pkg::item_t   held_item
);

  logic             valid;
  fmtmr_pkg::item_t item;

  assign in_ready   = !valid || take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

[rtl/core/fmtmr_core.sv]
// Timer/status state and the per-beat update: register latch, preloads,
// enables, expiries, the microsecond clock and the mode flag. Depends on fmtmr_pkg.
module fmtmr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  fmtmr_pkg::item_t    item,
  output fmtmr_pkg::result_t  result
);

  logic [fmtmr_pkg::NOW_W-1:0]  now_us, now_us_next;
  logic [fmtmr_pkg::REG_W-1:0]  reg_latch, reg_latch_next;
  logic [fmtmr_pkg::BYTE_W-1:0] t1_preload, t1_preload_next;
  logic [fmtmr_pkg::BYTE_W-1:0] t2_preload, t2_preload_next;
  logic                         t1_on, t1_on_next;
  logic                         t2_on, t2_on_next;
  logic [fmtmr_pkg::NOW_W-1:0]  t1_expiry, t1_expiry_next;
  logic [fmtmr_pkg::NOW_W-1:0]  t2_expiry, t2_expiry_next;
  logic                         mode_flag, mode_flag_next;

  logic                         pre1_wr, pre2_wr;
  logic [fmtmr_pkg::BYTE_W-1:0] t1_pre_sel, t2_pre_sel;
  logic [fmtmr_pkg::NOW_W-1:0]  t1_exp_cand, t2_exp_cand;
  logic                         is_data;

  assign is_data = (fmtmr_pkg::req_t'(item.req_type) == fmtmr_pkg::REQ_DATA_WRITE);
  assign pre1_wr = is_data && (reg_latch == fmtmr_pkg::REG_T1_PRELOAD);
  assign pre2_wr = is_data && (reg_latch == fmtmr_pkg::REG_T2_PRELOAD);

  // a preload write restarts from the new value, a control write from the stored one
  assign t1_pre_sel  = pre1_wr ? item.value : t1_preload;
  assign t2_pre_sel  = pre2_wr ? item.value : t2_preload;
  assign t1_exp_cand = now_us + fmtmr_pkg::NOW_W'(
                         fmtmr_pkg::timer_delta(t1_pre_sel, fmtmr_pkg::T1_TICK_US));
  assign t2_exp_cand = now_us + fmtmr_pkg::NOW_W'(
                         fmtmr_pkg::timer_delta(t2_pre_sel, fmtmr_pkg::T2_TICK_US));

  always_comb begin
    now_us_next     = now_us;
    reg_latch_next  = reg_latch;
    t1_preload_next = t1_preload;
    t2_preload_next = t2_preload;
    t1_on_next      = t1_on;
    t2_on_next      = t2_on;
    t1_expiry_next  = t1_expiry;
    t2_expiry_next  = t2_expiry;
    mode_flag_next  = mode_flag;
    result          = '0;

    unique case (fmtmr_pkg::req_t'(item.req_type))
      fmtmr_pkg::REQ_ADDR_BANK0: begin
        reg_latch_next = {1'b0, item.value};
      end
      fmtmr_pkg::REQ_ADDR_BANK1: begin
        reg_latch_next = {1'b1, item.value};
      end
      fmtmr_pkg::REQ_DATA_WRITE: begin
        case (reg_latch)
          fmtmr_pkg::REG_T1_PRELOAD: begin
            t1_preload_next = item.value;
            if (t1_on) t1_expiry_next = t1_exp_cand;
          end
          fmtmr_pkg::REG_T2_PRELOAD: begin
            t2_preload_next = item.value;
            if (t2_on) t2_expiry_next = t2_exp_cand;
          end
          fmtmr_pkg::REG_T_CONTROL: begin
            if (item.value[7]) begin
              // reset-flags bit: both off, expiries untouched
              t1_on_next = 1'b0;
              t2_on_next = 1'b0;
            end else begin
              if (!item.value[6]) begin
                t1_on_next = item.value[0];
                if (item.value[0]) t1_expiry_next = t1_exp_cand;
              end
              if (!item.value[5]) begin
                t2_on_next = item.value[1];
                if (item.value[1]) t2_expiry_next = t2_exp_cand;
              end
            end
          end
          default: begin
            if (reg_latch == fmtmr_pkg::REG_NEW_MODE) mode_flag_next = item.value[0];
            result.fwd_valid = 1'b1;
            result.fwd_reg   = reg_latch;
            result.fwd_data  = item.value;
          end
        endcase
      end
      fmtmr_pkg::REQ_STATUS_RD: begin
        if (t1_on && (now_us > t1_expiry))
          result.read_data = result.read_data | fmtmr_pkg::STAT_IRQ | fmtmr_pkg::STAT_T1;
        if (t2_on && (now_us > t2_expiry))
          result.read_data = result.read_data | fmtmr_pkg::STAT_IRQ | fmtmr_pkg::STAT_T2;
      end
      fmtmr_pkg::REQ_BANK1_RD: begin
        result.read_data = fmtmr_pkg::BANK1_RD_DATA;
      end
      fmtmr_pkg::REQ_ADVANCE: begin
        now_us_next = now_us + fmtmr_pkg::NOW_W'(item.advance_us);
      end
      default: begin
      end
    endcase

    result.wide_mode = mode_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_us     <= '0;
      reg_latch  <= '0;
      t1_preload <= '0;
      t2_preload <= '0;
      t1_on      <= 1'b0;
      t2_on      <= 1'b0;
      t1_expiry  <= '0;
      t2_expiry  <= '0;
      mode_flag  <= 1'b0;
    end else if (fire) begin
      now_us     <= now_us_next;
      reg_latch  <= reg_latch_next;
      t1_preload <= t1_preload_next;
      t2_preload <= t2_preload_next;
      t1_on      <= t1_on_next;
      t2_on      <= t2_on_next;
      t1_expiry  <= t1_expiry_next;
      t2_expiry  <= t2_expiry_next;
      mode_flag  <= mode_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_clock_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !(fire && fmtmr_pkg::req_t'(item.req_type) == fmtmr_pkg::REQ_ADVANCE) |=> $stable(now_us))
    else $error("clock moved without an advance beat");

  a_timer_off_by_ctrl: assert property (@(posedge clk) disable iff (rst)
    ($fell(t1_on) || $fell(t2_on)) |->
      $past(fire && is_data && reg_latch == fmtmr_pkg::REG_T_CONTROL))
    else $error("timer disabled outside a control write");

  a_fwd_only_data: assert property (@(posedge clk) disable iff (rst)
    result.fwd_valid |-> (is_data && reg_latch != fmtmr_pkg::REG_T1_PRELOAD &&
                          reg_latch != fmtmr_pkg::REG_T2_PRELOAD &&
                          reg_latch != fmtmr_pkg::REG_T_CONTROL))
    else $error("forward flagged for a timer register or non-write");

  a_status_irq: assert property (@(posedge clk) disable iff (rst)
    (fmtmr_pkg::req_t'(item.req_type) == fmtmr_pkg::REQ_STATUS_RD) |->
      (result.read_data[7] == (result.read_data[6] || result.read_data[5])))
    else $error("status summary bit disagrees with timer flags");
`endif

endmodule

[rtl/core/fmtmr_out_reg.sv]
// Result register: holds one finished result until the downstream side takes it.
// Depends on fmtmr_pkg.
module fmtmr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fmtmr_pkg::result_t  load_result,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output fmtmr_pkg::result_t  out_result
);

  logic               valid;
  fmtmr_pkg::result_t res;

  assign can_load   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res <= load_result;
    end
  end

endmodule

[rtl/core/fm_chip_timer_status_model_unit.sv]
// FM chip timer/status model, top level: input register, core, result register.
// Depends on fmtmr_pkg, fmtmr_in_reg, fmtmr_core, fmtmr_out_reg.
//
// Models the register port of an OPL2/OPL3-style FM chip for its two timers
// and its status byte. Each input beat is a bus access (address write per
// bank, data write, status read, bank-1 read) or a time advance of up to
// 2^20-1 us on a wrapping 64-bit microsecond clock; each gives exactly one
// result beat carrying the status byte, an optional forwarded register write
// and the current OPL3 mode flag. One beat is taken every cycle while the
// result register can load (it is empty or downstream is ready); the input
// register captures an accepted beat, the result register its result when
// the core takes it. The per-cycle work is set by the core stage: a constant
// multiply and a 64-bit add for timer expiry, or a 64-bit compare for status.
module fm_chip_timer_status_model_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[7:0], advance_us[27:8], zero pad
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_data[7:0], fwd_reg[16:8], fwd_data[24:17],
                                     // wide_mode[25], zero pad
  output logic        m_axis_tuser   // fwd_valid
);

  fmtmr_pkg::item_t   in_item, held_item;
  fmtmr_pkg::result_t core_result, out_result;
  logic               held_valid, can_load, fire;

  assign in_item.req_type   = s_axis_tuser;
  assign in_item.value      = s_axis_tdata[7:0];
  assign in_item.advance_us = s_axis_tdata[27:8];

  assign fire = held_valid && can_load;

  fmtmr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  fmtmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .result (core_result)
  );

  fmtmr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (held_valid),
    .load_result (core_result),
    .can_load    (can_load),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_result  (out_result)
  );

  assign m_axis_tdata = {6'b0, out_result.wide_mode, out_result.fwd_data,
                         out_result.fwd_reg, out_result.read_data};
  assign m_axis_tuser = out_result.fwd_valid;

endmodule
